// ----- rtl/rat_pkg.sv -----
// ----------------------------------------------------------------------------
// Row activation tracker package
// Sizes, register codes, shared types and the saturating increment used by
// the activation tracker and its table and scan units.
// ----------------------------------------------------------------------------
package rat_pkg;

   // Table geometry.
   localparam int BANK_COUNT  = 32;
   localparam int MAX_ENTRIES = 16;
   localparam int ROW_BITS    = 16;
   localparam int COUNT_BITS  = 16;

   localparam int BANK_W      = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
   localparam int ENTRY_W     = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int ENT_CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int ADDR_W      = BANK_W + ENTRY_W;
   localparam int TABLE_DEPTH = BANK_COUNT * (1 << ENTRY_W);

   // Port field widths.
   localparam int BANK_IN_W  = 5;
   localparam int ROW_IN_W   = 16;
   localparam int THR_W      = 16;
   localparam int PERIOD_W   = 32;
   localparam int NUSE_W     = 5;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Register reset values.
   localparam logic [THR_W-1:0]    THRESHOLD_RESET = 16'd4096;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 32'd50000000;
   localparam logic [NUSE_W-1:0]   NUSE_RESET      = 5'd16;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_PERIOD    = 2'd1,
      CSR_ENTRIES   = 2'd2
   } csr_index_type;

   // One table entry as stored in the memory.
   typedef struct packed {
      logic                  valid;
      logic [ROW_BITS-1:0]   row;
      logic [COUNT_BITS-1:0] count;
   } entry_type;

   // Control from the sequencer to the scan unit.
   typedef struct packed {
      logic               clear;
      logic               step;
      logic               in_use;
      logic [ENTRY_W-1:0] idx;
   } scan_ctl_type;

   // Outcome of a scan over one bank.
   typedef struct packed {
      logic                  hit;
      logic [ENTRY_W-1:0]    hit_idx;
      logic [COUNT_BITS-1:0] hit_count;
      logic                  free;
      logic [ENTRY_W-1:0]    free_idx;
   } scan_res_type;

   // Increment that sticks at the largest count.
   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      logic [COUNT_BITS-1:0] r;
      r = (v == COUNT_MAX) ? v : v + 1'b1;
      return r;
   endfunction

endpackage

// ----- rtl/rat_table.sv -----
// ----------------------------------------------------------------------------
// Row activation tracker entry table
// Single write port, single registered read port memory holding the row tag,
// valid flag and count of every entry of every bank.
// ----------------------------------------------------------------------------
module rat_table (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [rat_pkg::ADDR_W-1:0] rd_addr,
   input  logic                      wr_en,
   input  logic [rat_pkg::ADDR_W-1:0] wr_addr,
   input  rat_pkg::entry_type        wr_data,
   output rat_pkg::entry_type        rd_data
);
   import rat_pkg::*;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/rat_scan.sv -----
// ----------------------------------------------------------------------------
// Row activation tracker scan unit
// Shared compare unit that looks at one entry per cycle and keeps the first
// matching entry and the first entry whose count equals the spillover value.
// ----------------------------------------------------------------------------
module rat_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  rat_pkg::scan_ctl_type         ctl,
   input  rat_pkg::entry_type            entry,
   input  logic [rat_pkg::ROW_BITS-1:0]   row,
   input  logic [rat_pkg::COUNT_BITS-1:0] spill,
   output rat_pkg::scan_res_type         res
);
   import rat_pkg::*;

   scan_res_type res_ff;
   scan_res_type res_in;

   // Keep the lowest-index match and the lowest-index replaceable entry.
   always_comb begin
      res_in = res_ff;
      if (ctl.clear) begin
         res_in = '0;
      end else if (ctl.step && ctl.in_use) begin
         if (!res_ff.hit && entry.valid && (entry.row == row)) begin
            res_in.hit       = 1'b1;
            res_in.hit_idx   = ctl.idx;
            res_in.hit_count = entry.count;
         end
         if (!res_ff.free && (entry.count == spill)) begin
            res_in.free     = 1'b1;
            res_in.free_idx = ctl.idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

// ----- rtl/rowhammer_activation_tracker.sv -----
// ----------------------------------------------------------------------------
// Rowhammer activation tracker
// Per-bank counter table that flags rows activated often enough to need a
// victim refresh, with a periodic bulk clear driven by tick commands.
// Usage: a command is taken when start is high and busy is low. A tick
// command (req_action high) or an activation to a bank out of range
// answers in the next cycle and busy stays low. An activation scans the
// 16 entries of its bank through one compare unit, one entry per table
// read, and its response comes in the same cycle that busy falls. Every
// command gives one response: rsp_valid is high for exactly one cycle and
// the receiver cannot stall it. The user must write registers through the
// csr_ channel only while the block is idle; the block itself does not
// enforce this, and csr_ready is always high. Reset clears the
// sequencer, the tick counter, the spillover counters and the per-bank
// flags that mark a bank's table contents and counts as current; no
// clearing pass is needed, since a bank is normalized during its first scan.
// ----------------------------------------------------------------------------
module rowhammer_activation_tracker (
   input  logic                            clock,
   input  logic                            reset,
   // Command channel.
   input  logic                            start,
   output logic                            busy,
   input  logic                            req_action,
   input  logic [rat_pkg::BANK_IN_W-1:0]   req_bank,
   input  logic [rat_pkg::ROW_IN_W-1:0]    req_row,
   // Response channel.
   output logic                            rsp_valid,
   output logic                            rsp_refresh_request,
   output logic [rat_pkg::BANK_IN_W-1:0]   rsp_refresh_bank,
   output logic [rat_pkg::ROW_IN_W-1:0]    rsp_refresh_row,
   // Configuration channel.
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [rat_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rat_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rat_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [BANK_W-1:0]     bank_ff, bank_in;
   logic [ROW_BITS-1:0]   row_ff, row_in;
   logic [ENT_CNT_W-1:0]  rd_cnt_ff, rd_cnt_in;
   logic                  proc_ff, proc_in;
   logic [ENTRY_W-1:0]    proc_idx_ff, proc_idx_in;

   logic [THR_W-1:0]      thr_ff, thr_in;
   logic [PERIOD_W-1:0]   period_ff, period_in;
   logic [NUSE_W-1:0]     nuse_ff, nuse_in;
   logic [PERIOD_W-1:0]   tick_ff, tick_in;

   logic [BANK_COUNT-1:0] seen_ff, seen_in;
   logic [BANK_COUNT-1:0] cnt_ok_ff, cnt_ok_in;
   logic [COUNT_BITS-1:0] spill_ff [BANK_COUNT];
   logic [COUNT_BITS-1:0] spill_in [BANK_COUNT];

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_req_ff, rsp_req_in;
   logic [BANK_IN_W-1:0]  rsp_bank_ff, rsp_bank_in;
   logic [ROW_IN_W-1:0]   rsp_row_ff, rsp_row_in;

   logic                  accept;
   logic                  bank_ok;
   logic                  tick_wrap;
   logic [PERIOD_W:0]     tick_next;
   logic                  rd_en;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   entry_type             wr_data;
   entry_type             rd_data;
   entry_type             ent_norm;
   logic                  need_norm;
   logic [COUNT_BITS-1:0] spill;
   logic [COUNT_BITS-1:0] hit_inc;
   logic                  over;
   scan_ctl_type          scan_ctl;
   scan_res_type          scan_res;

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign bank_ok   = (32'(req_bank) < 32'(BANK_COUNT));
   assign csr_ready = 1'b1;

   // Tick counter step and period compare.
   assign tick_next = {1'b0, tick_ff} + 1'b1;
   assign tick_wrap = (tick_next >= {1'b0, period_ff});

   // A bank not yet seen has all entries invalid; a bank whose counts were
   // bulk cleared reads every count as zero.
   assign spill     = spill_ff[bank_ff];
   assign need_norm = !(seen_ff[bank_ff] && cnt_ok_ff[bank_ff]);
   always_comb begin
      ent_norm       = rd_data;
      ent_norm.valid = rd_data.valid && seen_ff[bank_ff];
      ent_norm.count = cnt_ok_ff[bank_ff] ? rd_data.count : '0;
   end

   // Table reads walk every entry of the bank in order.
   assign rd_en   = (state_ff == ST_SCAN) && (rd_cnt_ff < ENT_CNT_W'(MAX_ENTRIES));
   assign rd_addr = {bank_ff, rd_cnt_ff[ENTRY_W-1:0]};

   // Scan unit control.
   always_comb begin
      scan_ctl        = '0;
      scan_ctl.clear  = accept;
      scan_ctl.step   = proc_ff;
      scan_ctl.idx    = proc_idx_ff;
      scan_ctl.in_use = (32'(proc_idx_ff) < 32'(nuse_ff));
   end

   // Hit handling: saturating increment and threshold check.
   assign hit_inc = sat_inc(scan_res.hit_count);
   assign over    = (32'(hit_inc) >= 32'(thr_ff));

   // Single write port: normalization during the scan, update afterwards.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = {bank_ff, proc_idx_ff};
      wr_data = ent_norm;
      if (proc_ff) begin
         wr_en = need_norm;
      end else if (state_ff == ST_UPDATE) begin
         if (scan_res.hit) begin
            wr_en         = 1'b1;
            wr_addr       = {bank_ff, scan_res.hit_idx};
            wr_data.valid = 1'b1;
            wr_data.row   = row_ff;
            wr_data.count = over ? spill : hit_inc;
         end else if (scan_res.free) begin
            wr_en         = 1'b1;
            wr_addr       = {bank_ff, scan_res.free_idx};
            wr_data.valid = 1'b1;
            wr_data.row   = row_ff;
            wr_data.count = sat_inc(spill);
         end
      end
   end

   // Sequencer and state updates.
   always_comb begin
      state_in     = state_ff;
      bank_in      = bank_ff;
      row_in       = row_ff;
      rd_cnt_in    = rd_cnt_ff;
      proc_in      = rd_en;
      proc_idx_in  = rd_cnt_ff[ENTRY_W-1:0];
      tick_in      = tick_ff;
      seen_in      = seen_ff;
      cnt_ok_in    = cnt_ok_ff;
      spill_in     = spill_ff;
      rsp_valid_in = 1'b0;
      rsp_req_in   = 1'b0;
      rsp_bank_in  = '0;
      rsp_row_in   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               bank_in   = BANK_W'(req_bank);
               row_in    = ROW_BITS'(req_row);
               rd_cnt_in = '0;
               if (req_action) begin
                  rsp_valid_in = 1'b1;
                  if (tick_wrap) begin
                     tick_in   = '0;
                     cnt_ok_in = '0;
                     for (int b = 0; b < BANK_COUNT; b++) begin
                        spill_in[b] = '0;
                     end
                  end else begin
                     tick_in = tick_next[PERIOD_W-1:0];
                  end
               end else if (!bank_ok) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (rd_en) begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
            if (proc_ff && (32'(proc_idx_ff) == 32'(MAX_ENTRIES - 1))) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in           = ST_IDLE;
            seen_in[bank_ff]   = 1'b1;
            cnt_ok_in[bank_ff] = 1'b1;
            rsp_valid_in       = 1'b1;
            if (scan_res.hit) begin
               if (over) begin
                  rsp_req_in  = 1'b1;
                  rsp_bank_in = BANK_IN_W'(bank_ff);
                  rsp_row_in  = ROW_IN_W'(row_ff);
               end
            end else if (!scan_res.free) begin
               spill_in[bank_ff] = sat_inc(spill);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration register writes.
   always_comb begin
      thr_in    = thr_ff;
      period_in = period_ff;
      nuse_in   = nuse_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD: thr_in    = csr_data[THR_W-1:0];
            CSR_PERIOD:    period_in = csr_data[PERIOD_W-1:0];
            CSR_ENTRIES:   nuse_in   = csr_data[NUSE_W-1:0];
            default: begin
               thr_in = thr_ff;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_cnt_ff    <= '0;
         proc_ff      <= 1'b0;
         tick_ff      <= '0;
         seen_ff      <= '0;
         cnt_ok_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THRESHOLD_RESET;
         period_ff    <= PERIOD_RESET;
         nuse_ff      <= NUSE_RESET;
         for (int b = 0; b < BANK_COUNT; b++) begin
            spill_ff[b] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rd_cnt_ff    <= rd_cnt_in;
         proc_ff      <= proc_in;
         tick_ff      <= tick_in;
         seen_ff      <= seen_in;
         cnt_ok_ff    <= cnt_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         thr_ff       <= thr_in;
         period_ff    <= period_in;
         nuse_ff      <= nuse_in;
         spill_ff     <= spill_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      bank_ff     <= bank_in;
      row_ff      <= row_in;
      proc_idx_ff <= proc_idx_in;
      rsp_req_ff  <= rsp_req_in;
      rsp_bank_ff <= rsp_bank_in;
      rsp_row_ff  <= rsp_row_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_refresh_request = rsp_req_ff;
   assign rsp_refresh_bank    = rsp_bank_ff;
   assign rsp_refresh_row     = rsp_row_ff;

   rat_table u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   rat_scan u_scan (
      .clock (clock),
      .reset (reset),
      .ctl   (scan_ctl),
      .entry (ent_norm),
      .row   (row_ff),
      .spill (spill),
      .res   (scan_res)
   );

`ifndef SYNTHESIS
   // A response only follows an update or a command answered at once.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past((state_ff == ST_UPDATE) ||
                          (start && !busy && (req_action || !bank_ok))))
      else $error("response without a finished transaction");

   // A refresh request always comes with the response strobe.
   a_req_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_refresh_request |-> rsp_valid)
      else $error("refresh request outside a response");

   // Responses without a refresh carry zero bank and row.
   a_zero_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_refresh_request) |->
         ((rsp_refresh_bank == '0) && (rsp_refresh_row == '0)))
      else $error("nonzero fields on a response without refresh");

   // After an update the bank's contents and counts are current.
   a_bank_flags: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(state_ff == ST_UPDATE)) |->
         (seen_ff[bank_ff] && cnt_ok_ff[bank_ff]))
      else $error("bank flags not set after update");

   // The read counter never runs past the bank's entries.
   a_rd_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (32'(rd_cnt_ff) <= 32'(MAX_ENTRIES)))
      else $error("scan read counter out of range");
`endif

endmodule

// ----- test/rowhammer_activation_tracker_tb.sv -----
// ----------------------------------------------------------------------------
// Rowhammer activation tracker testbench
// Drives tick and activation commands through the start/busy handshake and
// checks every response against a behavioral copy of the per-bank counter
// table or a checked directed step's pinned value. A short table of directed
// commands and register writes comes first, then several randomized phases,
// each with its own threshold, clear period and number of entries in use.
// ----------------------------------------------------------------------------
module rowhammer_activation_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rat_pkg::*;

   // One response as seen on the rsp_ ports.
   typedef struct packed {
      logic                 refresh_req;
      logic [BANK_IN_W-1:0] bank;
      logic [ROW_IN_W-1:0]  row;
   } refresh_rsp_type;

   typedef enum logic [1:0] {
      STEP_TICK,
      STEP_ACT,
      STEP_CSR
   } step_kind_type;

   // One line of the directed sequence.
   typedef struct packed {
      step_kind_type         kind;
      csr_index_type         reg_idx;
      logic [CSR_DATA_W-1:0] data;
      logic [BANK_IN_W-1:0]  bank;
      logic [ROW_IN_W-1:0]   row;
      logic                  checked;
      refresh_rsp_type       want;
   } dir_step_type;

   // Register setting and idle rate of one random phase.
   typedef struct packed {
      logic [THR_W-1:0]    threshold;
      logic [PERIOD_W-1:0] period;
      logic [NUSE_W-1:0]   entries;
      logic [7:0]          idle_pct;
   } phase_type;

   localparam refresh_rsp_type QUIET = '0;
   localparam int CYCLE_LIMIT = 150000;
   localparam int ITEMS_PER_PHASE = 66;
   localparam int DIR_LEN = 34;
   localparam int NUM_PHASES = 8;

   localparam dir_step_type DIRECTED [DIR_LEN] = '{
      // Fresh table: a tick and first sightings of a row stay quiet.
      '{STEP_TICK, CSR_THRESHOLD, 32'd0, 5'd0, 16'h0000, 1'b1, QUIET},
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd0, 16'h0000, 1'b1, QUIET},
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd31, 16'hFFFF, 1'b1, QUIET},
      // Threshold of two: the second activation of each row fires.
      '{STEP_CSR, CSR_THRESHOLD, 32'd2, 5'd0, 16'h0000, 1'b0, QUIET},
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd31, 16'hFFFF, 1'b1, '{1'b1, 5'd31, 16'hFFFF}},
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd0, 16'h0000, 1'b1, '{1'b1, 5'd0, 16'h0000}},
      // Zero threshold: a new row is quiet, its first hit fires.
      '{STEP_CSR, CSR_THRESHOLD, 32'd0, 5'd0, 16'h0000, 1'b0, QUIET},
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd5, 16'h1234, 1'b1, QUIET},
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd5, 16'h1234, 1'b1, '{1'b1, 5'd5, 16'h1234}},
      // No entries in use: the activation only feeds the spillover counter.
      '{STEP_CSR, CSR_ENTRIES, 32'd0, 5'd0, 16'h0000, 1'b0, QUIET},
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd5, 16'h1234, 1'b1, QUIET},
      // Oversized entry count and largest threshold, junk in the upper bits.
      '{STEP_CSR, CSR_ENTRIES, 32'hFFFF_FFFF, 5'd0, 16'h0000, 1'b0, QUIET},
      '{STEP_CSR, CSR_THRESHOLD, 32'h5A5A_FFFF, 5'd0, 16'h0000, 1'b0, QUIET},
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd5, 16'h1234, 1'b0, QUIET},
      // One entry and zero period: misses fight over entry zero.
      '{STEP_CSR, CSR_ENTRIES, 32'd1, 5'd0, 16'h0000, 1'b0, QUIET},
      '{STEP_CSR, CSR_PERIOD, 32'd0, 5'd0, 16'h0000, 1'b0, QUIET},
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd7, 16'hA5A5, 1'b0, QUIET},
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd7, 16'h5A5A, 1'b0, QUIET},
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd7, 16'h5A5A, 1'b0, QUIET},
      '{STEP_TICK, CSR_THRESHOLD, 32'd0, 5'd31, 16'hFFFF, 1'b1, QUIET},
      // Largest period, then a period below the running tick count.
      '{STEP_CSR, CSR_PERIOD, 32'hFFFF_FFFF, 5'd0, 16'h0000, 1'b0, QUIET},
      '{STEP_TICK, CSR_THRESHOLD, 32'd0, 5'd0, 16'h0000, 1'b1, QUIET},
      '{STEP_TICK, CSR_THRESHOLD, 32'd0, 5'd0, 16'h0000, 1'b1, QUIET},
      '{STEP_CSR, CSR_PERIOD, 32'd1, 5'd0, 16'h0000, 1'b0, QUIET},
      '{STEP_TICK, CSR_THRESHOLD, 32'd0, 5'd0, 16'h0000, 1'b1, QUIET},
      // Shrinking and growing the window leaves one row in two entries;
      // the lowest entry must win the final hit.
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd9, 16'h00FF, 1'b0, QUIET},
      '{STEP_CSR, CSR_ENTRIES, 32'd2, 5'd0, 16'h0000, 1'b0, QUIET},
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd9, 16'hFF00, 1'b0, QUIET},
      '{STEP_CSR, CSR_ENTRIES, 32'd1, 5'd0, 16'h0000, 1'b0, QUIET},
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd9, 16'hFF00, 1'b0, QUIET},
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd9, 16'hFF00, 1'b0, QUIET},
      '{STEP_CSR, CSR_ENTRIES, 32'd2, 5'd0, 16'h0000, 1'b0, QUIET},
      '{STEP_CSR, CSR_THRESHOLD, 32'd3, 5'd0, 16'h0000, 1'b0, QUIET},
      '{STEP_ACT, CSR_THRESHOLD, 32'd0, 5'd9, 16'hFF00, 1'b0, QUIET}
   };

   localparam phase_type PHASES [NUM_PHASES] = '{
      '{16'd3, 32'd40, 5'd4, 8'd9},
      '{16'd1, 32'd7, 5'd1, 8'd9},
      '{16'd5, 32'hFFFF_FFFF, 5'd16, 8'd0},
      '{16'd2, 32'd3, 5'd2, 8'd9},
      '{16'd0, 32'd20, 5'd3, 8'd9},
      '{16'hFFFF, 32'd1, 5'd16, 8'd9},
      '{16'd3, 32'd50, 5'd0, 8'd9},
      '{16'd4, 32'd100, 5'd8, 8'd9}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_action;
   logic [BANK_IN_W-1:0]  req_bank;
   logic [ROW_IN_W-1:0]   req_row;
   logic                  rsp_valid;
   logic                  rsp_refresh_request;
   logic [BANK_IN_W-1:0]  rsp_refresh_bank;
   logic [ROW_IN_W-1:0]   rsp_refresh_row;
   logic                  csr_valid;
   logic                  csr_ready;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Typed expectation riding along with a directed command.
   logic                  pin_check;
   refresh_rsp_type       pin_value;

   int                    idle_pct = 9;
   int                    mismatch_count = 0;
   int                    cycle_count = 0;
   refresh_rsp_type       expected_refresh [$];

   // Behavioral copy of the tracker state and registers.
   logic [ROW_BITS-1:0]   trk_row [BANK_COUNT][MAX_ENTRIES];
   logic                  trk_valid [BANK_COUNT][MAX_ENTRIES];
   logic [COUNT_BITS-1:0] trk_count [BANK_COUNT][MAX_ENTRIES];
   logic [COUNT_BITS-1:0] spill_count [BANK_COUNT];
   logic [PERIOD_W-1:0]   tick_count;
   logic [THR_W-1:0]      cfg_threshold;
   logic [PERIOD_W-1:0]   cfg_period;
   logic [NUSE_W-1:0]     cfg_entries;

   rowhammer_activation_tracker u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_bank            (req_bank),
      .req_row             (req_row),
      .rsp_valid           (rsp_valid),
      .rsp_refresh_request (rsp_refresh_request),
      .rsp_refresh_bank    (rsp_refresh_bank),
      .rsp_refresh_row     (rsp_refresh_row),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always #2 clock = ~clock;

   function automatic logic [COUNT_BITS-1:0] count_up(input logic [COUNT_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   // Counts and spillover counters go to zero; row tags and valid bits stay.
   function automatic void clear_counts();
      for (int b = 0; b < BANK_COUNT; b++) begin
         spill_count[b] = '0;
         for (int e = 0; e < MAX_ENTRIES; e++) begin
            trk_count[b][e] = '0;
         end
      end
   endfunction

   function automatic void restore_defaults();
      cfg_threshold = THRESHOLD_RESET;
      cfg_period    = PERIOD_RESET;
      cfg_entries   = NUSE_RESET;
      tick_count    = '0;
      clear_counts();
      for (int b = 0; b < BANK_COUNT; b++) begin
         for (int e = 0; e < MAX_ENTRIES; e++) begin
            trk_row[b][e]   = '0;
            trk_valid[b][e] = 1'b0;
         end
      end
   endfunction

   // Applies one command to the table copy and returns the response it earns.
   function automatic refresh_rsp_type apply_command(input logic act,
                                                     input logic [BANK_IN_W-1:0] bank,
                                                     input logic [ROW_IN_W-1:0] row);
      refresh_rsp_type       rsp;
      int                    window;
      int                    slot;
      int                    e;
      logic                  hit;
      logic [COUNT_BITS-1:0] spill;
      rsp = QUIET;
      if (act) begin
         if ({1'b0, tick_count} + 33'd1 >= {1'b0, cfg_period}) begin
            clear_counts();
            tick_count = '0;
         end else begin
            tick_count = tick_count + 1'b1;
         end
         return rsp;
      end
      window = (cfg_entries > MAX_ENTRIES) ? MAX_ENTRIES : int'(cfg_entries);
      spill  = spill_count[bank];
      hit    = 1'b0;
      slot   = 0;
      for (e = 0; e < window; e++) begin
         if (!hit && trk_valid[bank][e] && trk_row[bank][e] == row) begin
            hit  = 1'b1;
            slot = e;
         end
      end
      if (hit) begin
         trk_count[bank][slot] = count_up(trk_count[bank][slot]);
         if (trk_count[bank][slot] >= cfg_threshold) begin
            rsp = '{1'b1, bank, row};
            trk_count[bank][slot] = spill;
         end
         return rsp;
      end
      // A miss takes the lowest entry sitting at the spillover level.
      for (e = 0; e < window; e++) begin
         if (trk_count[bank][e] == spill) begin
            trk_row[bank][e]   = row;
            trk_valid[bank][e] = 1'b1;
            trk_count[bank][e] = count_up(spill);
            return rsp;
         end
      end
      spill_count[bank] = count_up(spill);
      return rsp;
   endfunction

   function automatic void log_mismatch(input string what, input refresh_rsp_type want,
                                        input refresh_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $write("mismatch (%s) at cycle %0d: expected req=%0d bank=%0d row=%h, ",
                what, cycle_count, want.refresh_req, want.bank, want.row);
         $display("got req=%0d bank=%0d row=%h", got.refresh_req, got.bank, got.row);
      end
   endfunction

   // Follows every handshake at the clock edge and checks each response.
   always @(posedge clock) begin : scoreboard
      refresh_rsp_type got;
      refresh_rsp_type want;
      refresh_rsp_type predicted;
      if (reset) begin
         restore_defaults();
         expected_refresh.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THRESHOLD: cfg_threshold = csr_data[THR_W-1:0];
               CSR_PERIOD:    cfg_period    = csr_data[PERIOD_W-1:0];
               CSR_ENTRIES:   cfg_entries   = csr_data[NUSE_W-1:0];
               default:       ;
            endcase
         end
         if (rsp_valid) begin
            got = {rsp_refresh_request, rsp_refresh_bank, rsp_refresh_row};
            if (expected_refresh.size() == 0) begin
               log_mismatch("nothing outstanding", QUIET, got);
            end else begin
               want = expected_refresh.pop_front();
               if (got.refresh_req !== want.refresh_req || got.bank !== want.bank ||
                   got.row !== want.row) begin
                  log_mismatch("response", want, got);
               end
            end
         end
         if (start && !busy) begin
            predicted = apply_command(req_action, req_bank, req_row);
            expected_refresh.insert(expected_refresh.size(),
                                    pin_check ? pin_value : predicted);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Presents one command after a random gap and returns once it is taken.
   task automatic issue(input logic act, input logic [BANK_IN_W-1:0] bank,
                        input logic [ROW_IN_W-1:0] row, input logic pinned,
                        input refresh_rsp_type want);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_action <= act;
      req_bank   <= bank;
      req_row    <= row;
      pin_check  <= pinned;
      pin_value  <= want;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Holds off new commands until every outstanding response is back.
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (expected_refresh.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [BANK_IN_W-1:0] hot_bank [3];
      logic [ROW_IN_W-1:0]  row_pool [6];
      logic [BANK_IN_W-1:0] bank;
      logic [ROW_IN_W-1:0]  row;
      reset      <= 1'b1;
      start      <= 1'b0;
      req_action <= 1'b0;
      req_bank   <= '0;
      req_row    <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_THRESHOLD;
      csr_data   <= '0;
      pin_check  <= 1'b0;
      pin_value  <= QUIET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed sequence; register writes wait for the block to go idle.
      foreach (DIRECTED[i]) begin
         case (DIRECTED[i].kind)
            STEP_CSR: begin
               settle();
               write_reg(DIRECTED[i].reg_idx, DIRECTED[i].data);
            end
            STEP_TICK: issue(1'b1, DIRECTED[i].bank, DIRECTED[i].row,
                             DIRECTED[i].checked, DIRECTED[i].want);
            default:   issue(1'b0, DIRECTED[i].bank, DIRECTED[i].row,
                             DIRECTED[i].checked, DIRECTED[i].want);
         endcase
      end

      // Random phases: most activations hammer a few rows of a few banks,
      // so entries fill, get displaced and reach the threshold.
      foreach (PHASES[p]) begin
         settle();
         write_reg(CSR_THRESHOLD, {16'($urandom), PHASES[p].threshold});
         write_reg(CSR_PERIOD, PHASES[p].period);
         write_reg(CSR_ENTRIES, {27'($urandom), PHASES[p].entries});
         idle_pct = int'(PHASES[p].idle_pct);
         foreach (hot_bank[k]) hot_bank[k] = BANK_IN_W'($urandom);
         foreach (row_pool[k]) row_pool[k] = ROW_IN_W'($urandom);
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 99) < 8) begin
               issue(1'b1, BANK_IN_W'($urandom), ROW_IN_W'($urandom), 1'b0, QUIET);
            end else begin
               if ($urandom_range(0, 99) < 80) bank = hot_bank[$urandom_range(0, 2)];
               else bank = BANK_IN_W'($urandom);
               if ($urandom_range(0, 99) < 75) row = row_pool[$urandom_range(0, 5)];
               else row = ROW_IN_W'($urandom);
               issue(1'b0, bank, row, 1'b0, QUIET);
            end
         end
      end

      settle();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && expected_refresh.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
